[hw/rtl/shtab_pkg.sv]
// shared constants, codes and types of the symbol hash table
package shtab_pkg;

	// table geometry
	localparam int BUCKETS = 256;
	localparam int WAYS    = 4;
	localparam int SLOTS   = BUCKETS * WAYS;

	// field widths
	localparam int HEAD_W   = 64;
	localparam int TAIL_W   = 8;
	localparam int ADDR_W   = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;
	localparam int BYTE_W   = 8;
	localparam int HEAD_BYTES = HEAD_W / BYTE_W;

	// nine bytes of at most 255 sum below 4096
	localparam int SUM_W  = 12;
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W = $clog2(WAYS + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FOUND    = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef struct packed {
		logic [HEAD_W-1:0] head;
		logic [TAIL_W-1:0] tail;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [SLOT_W-1:0] rd_slot;
		logic [SLOT_W-1:0] wr_slot;
	} entry_ctl_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [BKT_W-1:0]  bucket;
		logic [FILL_W-1:0] wr_fill;
	} fill_ctl_t;

endpackage

[hw/rtl/shtab_hash.sv]
// label canonicalization and additive bucket hash, registered on load
module shtab_hash (
	input  logic                        clk,
	input  logic                        load,
	input  logic [shtab_pkg::HEAD_W-1:0] label_head,
	input  logic [shtab_pkg::TAIL_W-1:0] label_tail,
	output logic [shtab_pkg::HEAD_W-1:0] head_q,
	output logic [shtab_pkg::TAIL_W-1:0] tail_q,
	output logic [shtab_pkg::BKT_W-1:0]  bucket_q
);
	import shtab_pkg::*;

	logic [HEAD_W-1:0] head_c;
	logic [TAIL_W-1:0] tail_c;
	logic [SUM_W-1:0]  sum_c;

	// drop every byte after the first zero byte and sum what is kept
	always_comb begin
		logic              alive;
		logic [BYTE_W-1:0] byte_v;
		alive  = 1'b1;
		head_c = '0;
		sum_c  = '0;
		for (int i = 0; i < HEAD_BYTES; i++) begin
			byte_v = label_head[HEAD_W-1-BYTE_W*i -: BYTE_W];
			if (byte_v == '0) begin
				alive = 1'b0;
			end
			if (alive) begin
				head_c[HEAD_W-1-BYTE_W*i -: BYTE_W] = byte_v;
				sum_c = sum_c + SUM_W'(byte_v);
			end
		end
		if (alive) begin
			tail_c = label_tail;
			sum_c  = sum_c + SUM_W'(label_tail);
		end else begin
			tail_c = '0;
		end
	end

	// capture canonical label and bucket with the input beat
	always_ff @(posedge clk) begin
		if (load) begin
			head_q   <= head_c;
			tail_q   <= tail_c;
			bucket_q <= BKT_W'(sum_c % BUCKETS);
		end
	end

endmodule

[hw/rtl/shtab_fill_ram.sv]
// per-bucket fill counts with reset-cleared valid bits
module shtab_fill_ram (
	input  logic                         clk,
	input  logic                         arst_n,
	input  shtab_pkg::fill_ctl_t         ctl,
	output logic [shtab_pkg::FILL_W-1:0] rd_fill
);
	import shtab_pkg::*;

	logic [FILL_W-1:0]  mem [BUCKETS];
	logic [BUCKETS-1:0] valid_q;
	logic [FILL_W-1:0]  rd_data_q;
	logic               rd_valid_q;

	// valid bit per bucket, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.bucket] <= 1'b1;
		end
	end

	// count storage with registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.bucket] <= ctl.wr_fill;
		end
		if (ctl.rd_en) begin
			rd_data_q  <= mem[ctl.bucket];
			rd_valid_q <= valid_q[ctl.bucket];
		end
	end

	// a bucket never written holds no entries
	assign rd_fill = rd_valid_q ? rd_data_q : '0;

endmodule

[hw/rtl/shtab_entry_ram.sv]
// entry store: label and address per slot, one write and one read port
module shtab_entry_ram (
	input  logic                  clk,
	input  shtab_pkg::entry_ctl_t ctl,
	input  shtab_pkg::entry_t     wr_data,
	output shtab_pkg::entry_t     rd_data_q
);
	import shtab_pkg::*;

	entry_t mem [SLOTS];

	// slot storage with registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_slot] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_slot];
		end
	end

endmodule

[hw/rtl/symbol_hash_table_unit.sv]
// symbol hash table top level: sequencer, shared label compare, result register
//
// Maps labels of up to nine bytes to 16-bit addresses in a bucketed table of
// BUCKETS buckets with WAYS entries each. Bytes after the first zero byte are
// taken as zero. The bucket is the byte sum modulo BUCKETS.
// Input beat: action (0 insert, 1 lookup), label_head, label_tail, address_in,
// under in_valid/in_stall. Output beat: status, address_out, buckets_in_use,
// under out_valid/out_stall. One output beat per input beat, in order.
// One item at a time: in_stall is high from acceptance until the result is
// loaded into the output register. An item passes S_FILL, which reads the
// bucket's fill count, then S_DECIDE; a lookup of a non-empty bucket then
// compares in S_COMPARE one entry after another (up to WAYS), since a single
// comparator walks the bucket through the one read port of the entry store,
// and S_DONE loads the result into the output register. A new item is taken
// while a result waits in the output register; a finished result waits in
// S_DONE while out_stall holds the previous one. Reset empties the table and
// clears the bucket count at once; no clearing pass is needed after reset.
module symbol_hash_table_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [shtab_pkg::HEAD_W-1:0]   label_head,
	input  logic [shtab_pkg::TAIL_W-1:0]   label_tail,
	input  logic [shtab_pkg::ADDR_W-1:0]   address_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [shtab_pkg::STATUS_W-1:0] status,
	output logic [shtab_pkg::ADDR_W-1:0]   address_out,
	output logic [shtab_pkg::COUNT_W-1:0]  buckets_in_use
);
	import shtab_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_FILL    = 6'b000010,
		S_DECIDE  = 6'b000100,
		S_COMPARE = 6'b001000,
		S_DONE    = 6'b010000,
		S_SPARE   = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic              accept;
	logic              action_q;
	logic [ADDR_W-1:0] addr_q;
	logic [HEAD_W-1:0] head_q;
	logic [TAIL_W-1:0] tail_q;
	logic [BKT_W-1:0]  bucket_q;
	logic [FILL_W-1:0] fill_rd;
	logic [FILL_W-1:0] fill_cur_q;
	logic [FILL_W-1:0] way_q;
	logic [FILL_W-1:0] nxt_way;
	logic [SLOT_W-1:0] base_slot;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [COUNT_W-1:0] count_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [COUNT_W-1:0] out_count_q;
	logic              out_free;
	logic              match;
	entry_t            entry_rd;
	entry_t            entry_wr;
	entry_ctl_t        entry_ctl;
	fill_ctl_t         fill_ctl;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	shtab_hash u_hash (
		.clk        (clk),
		.load       (accept),
		.label_head (label_head),
		.label_tail (label_tail),
		.head_q     (head_q),
		.tail_q     (tail_q),
		.bucket_q   (bucket_q)
	);

	shtab_fill_ram u_fill (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fill_ctl),
		.rd_fill (fill_rd)
	);

	shtab_entry_ram u_entry (
		.clk       (clk),
		.ctl       (entry_ctl),
		.wr_data   (entry_wr),
		.rd_data_q (entry_rd)
	);

	// first slot of the bucket and the shared label comparator
	assign base_slot = SLOT_W'(SLOT_W'(bucket_q) * SLOT_W'(WAYS));
	assign match     = (entry_rd.head == head_q) && (entry_rd.tail == tail_q);
	assign nxt_way   = way_q + FILL_W'(1);

	assign entry_wr.head = head_q;
	assign entry_wr.tail = tail_q;
	assign entry_wr.addr = addr_q;

	// memory port control per sequencer state
	always_comb begin
		fill_ctl.rd_en     = (state_q == S_FILL);
		fill_ctl.wr_en     = 1'b0;
		fill_ctl.bucket    = bucket_q;
		fill_ctl.wr_fill   = fill_rd + FILL_W'(1);
		entry_ctl.rd_en    = 1'b0;
		entry_ctl.wr_en    = 1'b0;
		entry_ctl.rd_slot  = base_slot;
		entry_ctl.wr_slot  = base_slot + SLOT_W'(fill_rd);
		case (state_q)
			S_DECIDE: begin
				if (action_q == ACT_INSERT) begin
					if (fill_rd < FILL_W'(WAYS)) begin
						fill_ctl.wr_en  = 1'b1;
						entry_ctl.wr_en = 1'b1;
					end
				end else begin
					entry_ctl.rd_en = (fill_rd != '0);
				end
			end
			S_COMPARE: begin
				entry_ctl.rd_slot = base_slot + SLOT_W'(nxt_way);
				entry_ctl.rd_en   = !match && (nxt_way < fill_cur_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (action_q == ACT_LOOKUP && fill_rd != '0) begin
					state_d = S_COMPARE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_COMPARE: begin
				if (match || nxt_way >= fill_cur_q) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECIDE && action_q == ACT_INSERT && fill_rd == '0) begin
				count_q <= count_q + COUNT_W'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			addr_q   <= address_in;
		end
		case (state_q)
			S_DECIDE: begin
				fill_cur_q <= fill_rd;
				way_q      <= '0;
				res_addr_q <= '0;
				if (action_q == ACT_INSERT) begin
					res_status_q <= (fill_rd < FILL_W'(WAYS)) ? ST_INSERTED : ST_FULL;
				end else begin
					res_status_q <= ST_MISSING;
				end
			end
			S_COMPARE: begin
				way_q <= nxt_way;
				if (match) begin
					res_status_q <= ST_FOUND;
					res_addr_q   <= entry_rd.addr;
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign address_out    = out_addr_q;
	assign buckets_in_use = out_count_q;

endmodule
